### src/scfr_pkg.sv
// shared constants and types of the sum-checked frame receiver
package scfr_pkg;

    localparam int BYTE_W                = 8;
    localparam int PAYLOAD_W             = 6;
    localparam int HDR_BYTES             = 4;
    localparam int DEFAULT_MAX_FRAME_LEN = 64;
    localparam int QUEUE_DEPTH           = 2;

    localparam logic [BYTE_W-1:0] RESET_START_BYTE   = 8'hAA;
    localparam logic [BYTE_W-1:0] RESET_ADDRESS_BYTE = 8'hAF;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ADDRESS_BYTE = 1'b1;

    // payload buffer write from the parser
    typedef struct packed {
        logic                 en;
        logic                 bank;
        logic [PAYLOAD_W-1:0] offset;
        logic [BYTE_W-1:0]    data;
    } t_wr;

    // one checked frame waiting to be drained
    typedef struct packed {
        logic                 bank;
        logic [BYTE_W-1:0]    id;
        logic [PAYLOAD_W-1:0] len;
    } t_desc;

endpackage

### src/scfr_if.sv
// channel interfaces: received bytes, frame results and configuration writes
interface scfr_in_if;
    logic                           valid;
    logic                           ready;
    logic [scfr_pkg::BYTE_W-1:0]    rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface scfr_out_if;
    logic                           valid;
    logic                           ready;
    logic [scfr_pkg::BYTE_W-1:0]    msg_id;
    logic [scfr_pkg::BYTE_W-1:0]    payload_byte;
    logic [scfr_pkg::PAYLOAD_W-1:0] payload_index;
    logic [scfr_pkg::PAYLOAD_W-1:0] payload_len;
    logic                           last;
    modport source (output valid, output msg_id, output payload_byte, output payload_index,
                    output payload_len, output last, input ready);
    modport sink   (input valid, input msg_id, input payload_byte, input payload_index,
                    input payload_len, input last, output ready);
endinterface

interface scfr_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [scfr_pkg::CFG_IDX_W-1:0] index;
    logic [scfr_pkg::BYTE_W-1:0]    data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### src/scfr_front.sv
// frame parser: hunts, checks header and checksum, writes payload, queues good frames
module scfr_front #(
    parameter int MAX_FRAME_LEN = scfr_pkg::DEFAULT_MAX_FRAME_LEN
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    scfr_in_if.sink        i_in,
    scfr_cfg_if.sink       i_cfg,
    input  logic           i_q_full,
    output logic           o_q_push,
    output scfr_pkg::t_desc o_desc,
    output scfr_pkg::t_wr  o_wr
);

    localparam logic [2:0] ST_HUNT = 3'd0;
    localparam logic [2:0] ST_LEN  = 3'd1;
    localparam logic [2:0] ST_ADDR = 3'd2;
    localparam logic [2:0] ST_ID   = 3'd3;
    localparam logic [2:0] ST_DATA = 3'd4;
    localparam logic [2:0] ST_SUM  = 3'd5;

    logic [2:0]                     r_state, n_state;
    logic [scfr_pkg::PAYLOAD_W-1:0] r_count, n_count;
    logic [scfr_pkg::PAYLOAD_W-1:0] r_expected, n_expected;
    logic [scfr_pkg::BYTE_W-1:0]    r_sum, n_sum;
    logic [scfr_pkg::BYTE_W-1:0]    r_id, n_id;
    logic                           r_bank, n_bank;
    logic [scfr_pkg::BYTE_W-1:0]    r_start_byte;
    logic [scfr_pkg::BYTE_W-1:0]    r_address_byte;

    logic                           accept;
    logic [scfr_pkg::BYTE_W-1:0]    b;
    logic                           len_ok;
    logic [scfr_pkg::PAYLOAD_W-1:0] count_inc;

    assign i_in.ready  = !i_q_full;
    assign accept      = i_in.valid && i_in.ready;
    assign b           = i_in.rx_byte;
    assign i_cfg.ready = 1'b1;

    assign len_ok    = ({1'b0, b} >= 9'(scfr_pkg::HDR_BYTES + 1))
                    && ({1'b0, b} < 9'(MAX_FRAME_LEN));
    assign count_inc = r_count + 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte   <= scfr_pkg::RESET_START_BYTE;
            r_address_byte <= scfr_pkg::RESET_ADDRESS_BYTE;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                scfr_pkg::CFG_START_BYTE:   r_start_byte   <= i_cfg.data;
                scfr_pkg::CFG_ADDRESS_BYTE: r_address_byte <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // parser next state
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_expected = r_expected;
        n_sum      = r_sum;
        n_id       = r_id;
        n_bank     = r_bank;
        o_q_push   = 1'b0;
        if (accept) begin
            unique case (r_state)
                ST_HUNT: begin
                    if (b == r_start_byte) n_state = ST_LEN;
                end
                ST_LEN: begin
                    if (len_ok) begin
                        n_expected = scfr_pkg::PAYLOAD_W'(b - 8'(scfr_pkg::HDR_BYTES));
                        n_count    = '0;
                        n_sum      = b;
                        n_state    = ST_ADDR;
                    end else begin
                        n_state = ST_HUNT;
                    end
                end
                ST_ADDR: begin
                    n_sum   = r_sum + b;
                    n_state = (b == r_address_byte) ? ST_ID : ST_HUNT;
                end
                ST_ID: begin
                    n_id    = b;
                    n_sum   = r_sum + b;
                    n_state = ST_DATA;
                end
                ST_DATA: begin
                    n_sum   = r_sum + b;
                    n_count = count_inc;
                    if (count_inc == r_expected) n_state = ST_SUM;
                end
                ST_SUM: begin
                    // good frame: hand it to the drain side and switch banks
                    if (r_sum == b) begin
                        o_q_push = 1'b1;
                        n_bank   = ~r_bank;
                    end
                    n_state = ST_HUNT;
                end
                default: n_state = ST_HUNT;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_HUNT;
            r_count    <= '0;
            r_expected <= '0;
            r_sum      <= '0;
            r_id       <= '0;
            r_bank     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_expected <= n_expected;
            r_sum      <= n_sum;
            r_id       <= n_id;
            r_bank     <= n_bank;
        end
    end

    // descriptor and payload write
    assign o_desc.bank = r_bank;
    assign o_desc.id   = r_id;
    assign o_desc.len  = r_expected;

    assign o_wr.en     = accept && (r_state == ST_DATA);
    assign o_wr.bank   = r_bank;
    assign o_wr.offset = r_count;
    assign o_wr.data   = b;

endmodule

### src/scfr_queue.sv
// two-entry queue of checked frame descriptors between parser and drain
module scfr_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  scfr_pkg::t_desc i_desc,
    input  logic            i_pop,
    output scfr_pkg::t_desc o_head,
    output logic            o_full,
    output logic            o_empty
);

    localparam int PTR_W = $clog2(scfr_pkg::QUEUE_DEPTH);

    scfr_pkg::t_desc r_mem [scfr_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [PTR_W:0]   r_cnt;

    assign o_full  = (r_cnt == (PTR_W+1)'(scfr_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rptr];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wptr] <= i_desc;
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) r_wptr <= r_wptr + 1'b1;
            if (i_pop)  r_rptr <= r_rptr + 1'b1;
            r_cnt <= r_cnt + (PTR_W+1)'(i_push) - (PTR_W+1)'(i_pop);
        end
    end

endmodule

### src/scfr_back.sv
// drain side: two-bank payload buffer, read sequencer and output register
module scfr_back #(
    parameter int MAX_FRAME_LEN = scfr_pkg::DEFAULT_MAX_FRAME_LEN
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  scfr_pkg::t_wr   i_wr,
    input  scfr_pkg::t_desc i_head,
    input  logic            i_q_empty,
    output logic            o_q_pop,
    scfr_out_if.source      o_out
);

    localparam int ADDR_W    = $clog2(MAX_FRAME_LEN - scfr_pkg::HDR_BYTES);
    localparam int MEM_DEPTH = 2 * (2 ** ADDR_W);

    logic [scfr_pkg::BYTE_W-1:0]    r_mem [MEM_DEPTH];

    logic [scfr_pkg::PAYLOAD_W-1:0] r_k;
    logic                           r_pend;
    logic [scfr_pkg::BYTE_W-1:0]    r_rdata;
    logic [scfr_pkg::BYTE_W-1:0]    r_p_id;
    logic [scfr_pkg::PAYLOAD_W-1:0] r_p_idx;
    logic [scfr_pkg::PAYLOAD_W-1:0] r_p_len;
    logic                           r_p_last;

    logic                           r_ovalid;
    logic [scfr_pkg::BYTE_W-1:0]    r_o_id;
    logic [scfr_pkg::BYTE_W-1:0]    r_o_byte;
    logic [scfr_pkg::PAYLOAD_W-1:0] r_o_idx;
    logic [scfr_pkg::PAYLOAD_W-1:0] r_o_len;
    logic                           r_o_last;

    logic                           out_load;
    logic                           issue;
    logic                           k_last;

    assign out_load = r_pend && (!r_ovalid || o_out.ready);
    assign issue    = !i_q_empty && (!r_pend || out_load);
    assign k_last   = ((r_k + 1'b1) == i_head.len);
    // the bank is released once its final byte has been read
    assign o_q_pop  = issue && k_last;

    // payload buffer
    always_ff @(posedge i_clk) begin
        if (i_wr.en) r_mem[{i_wr.bank, i_wr.offset[ADDR_W-1:0]}] <= i_wr.data;
        if (issue)   r_rdata <= r_mem[{i_head.bank, r_k[ADDR_W-1:0]}];
    end

    // result fields travelling with the read
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_p_id   <= i_head.id;
            r_p_idx  <= r_k;
            r_p_len  <= i_head.len;
            r_p_last <= k_last;
        end
    end

    // read position and read-pending flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k    <= '0;
            r_pend <= 1'b0;
        end else begin
            if (issue) r_k <= k_last ? '0 : r_k + 1'b1;
            if (issue)         r_pend <= 1'b1;
            else if (out_load) r_pend <= 1'b0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_load) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_id   <= r_p_id;
            r_o_byte <= r_rdata;
            r_o_idx  <= r_p_idx;
            r_o_len  <= r_p_len;
            r_o_last <= r_p_last;
        end
    end

    assign o_out.valid         = r_ovalid;
    assign o_out.msg_id        = r_o_id;
    assign o_out.payload_byte  = r_o_byte;
    assign o_out.payload_index = r_o_idx;
    assign o_out.payload_len   = r_o_len;
    assign o_out.last          = r_o_last;

endmodule

### src/sum_checked_frame_receiver.sv
// top level of the sum-checked frame receiver
//
//  channel   dir  beat
//  i_in      in   rx_byte, one received byte
//  o_out     out  msg_id, payload_byte, payload_index, payload_len, last
//  i_cfg     in   index, data: start byte (0) or address byte (1)
//
// the parser takes one byte per cycle; a good checksum beat queues the frame
// and its results pass the read and output registers, one result per cycle
// while o_out.ready is high. the payload buffer has two banks, so the parser
// stalls (i_in.ready low) only while two checked frames still wait to drain.
// synchronous reset clears control state; the buffer itself is not cleared.
module sum_checked_frame_receiver #(
    parameter int MAX_FRAME_LEN = scfr_pkg::DEFAULT_MAX_FRAME_LEN
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    scfr_in_if.sink     i_in,
    scfr_cfg_if.sink    i_cfg,
    scfr_out_if.source  o_out
);

    logic            q_push;
    logic            q_pop;
    logic            q_full;
    logic            q_empty;
    scfr_pkg::t_desc desc;
    scfr_pkg::t_desc head;
    scfr_pkg::t_wr   wr;

    scfr_front #(
        .MAX_FRAME_LEN (MAX_FRAME_LEN)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cfg    (i_cfg),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_desc   (desc),
        .o_wr     (wr)
    );

    scfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_desc  (desc),
        .i_pop   (q_pop),
        .o_head  (head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    scfr_back #(
        .MAX_FRAME_LEN (MAX_FRAME_LEN)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (wr),
        .i_head    (head),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .o_out     (o_out)
    );

    // a frame is never queued over a full queue
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("frame queued while queue full");

    // the drain never releases a bank that was not queued
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("queue popped while empty");

    // the last beat of a frame sits at the final payload position
    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.last) |-> (o_out.payload_index + 1'b1 == o_out.payload_len))
        else $error("last beat at wrong payload index");

    // payload is never written into a bank whose frame is still queued
    a_wr_bank_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr.en && !q_empty) |-> (wr.bank != head.bank))
        else $error("payload write into a bank still draining");

endmodule
